// ----- rtl/epx_pixel_upscale_2x_defines.svh -----
// assertion macros for the epx upscaler checker
`ifndef EPX_PIXEL_UPSCALE_2X_DEFINES_SVH
`define EPX_PIXEL_UPSCALE_2X_DEFINES_SVH

// concurrent check, masked while reset is asserted
`define EPX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define EPX_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/epx_pkg.sv -----
// shared types, constants and the corner rule of the epx upscaler
`timescale 1ns / 1ps

package epx_pkg;

  localparam int PIX_W     = 8;
  localparam int POS_W     = 10;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  // result slots of one pixel, in emission order
  localparam int SLOT_ABOVE = 0;
  localparam int SLOT_LEFT  = 1;
  localparam int SLOT_FINAL = 2;
  localparam int NUM_SLOTS  = 3;

  typedef logic [PIX_W-1:0] px_t;

  typedef struct packed {
    px_t tl;
    px_t tr;
    px_t bl;
    px_t br;
  } quad_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    quad_t            q;
    logic             done;
  } blk_t;

  function automatic quad_t epx_corners(px_t p, px_t up, px_t left, px_t right, px_t down);
    quad_t q;
    q.tl = (left == up && left != down && up != right) ? up : p;
    q.tr = (up == right && up != left && right != down) ? right : p;
    q.bl = (down == left && down != right && left != up) ? left : p;
    q.br = (right == down && right != up && down != left) ? down : p;
    return q;
  endfunction

endpackage

// ----- rtl/epx_line_store.sv -----
// two-row line store: one write port and two registered read ports
`timescale 1ns / 1ps

module epx_line_store #(
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             acc_en,
  input  logic [AW-1:0]    wr_addr,
  input  epx_pkg::px_t     wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  input  logic [AW-1:0]    rd_b_addr,
  output epx_pkg::px_t     rd_a_data,
  output epx_pkg::px_t     rd_b_data
);

  epx_pkg::px_t mem [DEPTH];

  // reads see the contents before this edge's write
  always_ff @(posedge clk) begin
    if (acc_en) begin
      rd_a_data     <= mem[rd_a_addr];
      rd_b_data     <= mem[rd_b_addr];
      mem[wr_addr]  <= wr_data;
    end
  end

endmodule

// ----- rtl/epx_pixel_upscale_2x.sv -----
// top level of the epx 2x pixel-art upscaler
`timescale 1ns / 1ps

// Source pixels enter on the in_ channel in raster order, one transaction per
// pixel. Each result transaction on the out_ channel is one 2x2 output block
// with its source column and row; out_frame_done marks the last block of a frame.
// The block above a pixel leaves once that pixel arrives; in the last row the
// block left of the pixel follows, and the final pixel also sends the final block.
// A block passes the work stage and output register once its pixel is accepted.
// One pixel per cycle while out_ready is high; last-row pixels that release two
// or three blocks stall the input while the single output register passes them on.
// Two line stores in one memory with two read ports hold the earlier rows; the
// window of the row above slides along in registers, one prefetch per pixel.
// cfg_ writes set source_width (index 0) and source_height (index 1); any such
// write restarts the frame. Write configuration only while the block is idle.
// Reset (rst_n low, synchronous) empties the pipeline, restarts the frame and
// loads 320 x 200. When out_ready is low the output holds its block, one more
// pixel that releases a block may enter the work stage, then in_ready drops.

module epx_pixel_upscale_2x #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [epx_pkg::PIX_W-1:0]           in_pixel_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [epx_pkg::POS_W-1:0]           out_block_col,
  output logic [epx_pkg::POS_W-1:0]           out_block_row,
  output logic [epx_pkg::PIX_W-1:0]           out_top_left,
  output logic [epx_pkg::PIX_W-1:0]           out_top_right,
  output logic [epx_pkg::PIX_W-1:0]           out_bottom_left,
  output logic [epx_pkg::PIX_W-1:0]           out_bottom_right,
  output logic                                out_frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [epx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [epx_pkg::DIM_W-1:0]           cfg_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int W_RST = (MAX_WIDTH < 320) ? MAX_WIDTH : 320;
  localparam int H_RST = (MAX_HEIGHT < 200) ? MAX_HEIGHT : 200;

  // last column / row index of the frame
  logic [CW-1:0] wl_r;
  logic [RW-1:0] hl_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  logic [CW-1:0] cfg_wl;
  logic [RW-1:0] cfg_hl;
  logic          cfg_we;
  logic          cfg_hit;

  logic          in_acc;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] nxt_col;
  logic [AW-1:0] cur_base;
  logic [AW-1:0] prv_base;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_a_addr;
  epx_pkg::px_t  rd_a_data;
  epx_pkg::px_t  rd_b_data;
  logic [epx_pkg::NUM_SLOTS-1:0] new_mask;

  // work stage
  epx_pkg::px_t  s_px_r;
  logic [CW-1:0] s_col_r;
  logic [RW-1:0] s_row_r;
  logic          s_c1_r;
  logic          s_c2_r;
  logic          s_r1_r;
  logic          s_r2_r;
  logic          s_lc_r;
  logic          byp_r;
  epx_pkg::px_t  win_c_r;
  epx_pkg::px_t  win_l_r;
  epx_pkg::px_t  rp0_r;
  epx_pkg::px_t  rp1_r;
  logic [epx_pkg::NUM_SLOTS-1:0] pend_r;
  logic [epx_pkg::NUM_SLOTS-1:0] pend_nxt;
  logic [epx_pkg::NUM_SLOTS-1:0] pend_left;
  logic [epx_pkg::NUM_SLOTS-1:0] pick;

  epx_pkg::px_t  right_q;
  epx_pkg::blk_t blk_a;
  epx_pkg::blk_t blk_b;
  epx_pkg::blk_t blk_c;
  epx_pkg::blk_t blk_sel;

  // output register
  epx_pkg::blk_t out_blk_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_free;
  logic          load_out;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == epx_pkg::REG_SOURCE_WIDTH) ||
                     (cfg_index == epx_pkg::REG_SOURCE_HEIGHT);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_wl = '0;
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      cfg_wl = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_wl = CW'(cfg_data - epx_pkg::DIM_W'(1));
    end
    if (cfg_data == '0) begin
      cfg_hl = '0;
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      cfg_hl = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_hl = RW'(cfg_data - epx_pkg::DIM_W'(1));
    end
  end

  // ---------------- position and line store addressing ----------------
  assign last_col = (col_r == wl_r);
  assign last_row = (row_r == hl_r);
  assign nxt_col  = last_col ? '0 : CW'(col_r + CW'(1));
  assign cur_base = row_r[0] ? AW'(MAX_WIDTH) : '0;
  assign prv_base = row_r[0] ? '0 : AW'(MAX_WIDTH);
  assign wr_addr  = AW'(cur_base + AW'(col_r));
  // prefetch the row-above pixel the next transaction will need as its centre
  assign rd_a_addr = AW'((last_col ? cur_base : prv_base) + AW'(nxt_col));

  always_comb begin
    new_mask = '0;
    new_mask[epx_pkg::SLOT_ABOVE] = (row_r != '0);
    new_mask[epx_pkg::SLOT_LEFT]  = last_row && (col_r != '0);
    new_mask[epx_pkg::SLOT_FINAL] = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= CW'(W_RST - 1);
      hl_r  <= RW'(H_RST - 1);
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          epx_pkg::REG_SOURCE_WIDTH:  wl_r <= cfg_wl;
          epx_pkg::REG_SOURCE_HEIGHT: hl_r <= cfg_hl;
          default: ;
        endcase
      end
      if (cfg_we && cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end else if (in_acc) begin
        col_r <= nxt_col;
        if (last_col) begin
          row_r <= last_row ? '0 : RW'(row_r + RW'(1));
        end
      end
    end
  end

  epx_line_store #(
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk       (clk),
    .acc_en    (in_acc),
    .wr_addr   (wr_addr),
    .wr_data   (in_pixel_in),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (wr_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // ---------------- work stage ----------------
  // one-pixel rows: the next row's centre is the pixel just written
  assign right_q = byp_r ? s_px_r : rd_a_data;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_px_r  <= in_pixel_in;
      s_col_r <= col_r;
      s_row_r <= row_r;
      s_c1_r  <= (col_r != '0);
      s_c2_r  <= (32'(col_r) >= 2);
      s_r1_r  <= (row_r != '0);
      s_r2_r  <= (32'(row_r) >= 2);
      s_lc_r  <= last_col;
      byp_r   <= last_col && (col_r == '0);
      win_c_r <= right_q;
      win_l_r <= win_c_r;
      rp0_r   <= s_px_r;
      rp1_r   <= rp0_r;
    end
  end

  always_comb begin
    epx_pkg::px_t a_left;
    epx_pkg::px_t a_right;
    epx_pkg::px_t a_up;
    epx_pkg::px_t b_left;
    epx_pkg::px_t b_up;
    epx_pkg::px_t c_left;
    epx_pkg::px_t c_up;

    // block above the current pixel
    a_left  = s_c1_r ? win_l_r : win_c_r;
    a_right = s_lc_r ? win_c_r : right_q;
    a_up    = s_r2_r ? rd_b_data : win_c_r;
    blk_a.col  = epx_pkg::POS_W'(s_col_r);
    blk_a.row  = epx_pkg::POS_W'(RW'(s_row_r - RW'(1)));
    blk_a.q    = epx_pkg::epx_corners(win_c_r, a_up, a_left, a_right, s_px_r);
    blk_a.done = 1'b0;

    // last row: block left of the current pixel
    b_left = s_c2_r ? rp1_r : rp0_r;
    b_up   = s_r1_r ? win_l_r : rp0_r;
    blk_b.col  = epx_pkg::POS_W'(CW'(s_col_r - CW'(1)));
    blk_b.row  = epx_pkg::POS_W'(s_row_r);
    blk_b.q    = epx_pkg::epx_corners(rp0_r, b_up, b_left, s_px_r, rp0_r);
    blk_b.done = 1'b0;

    // last block of the frame
    c_left = s_c1_r ? rp0_r : s_px_r;
    c_up   = s_r1_r ? win_c_r : s_px_r;
    blk_c.col  = epx_pkg::POS_W'(s_col_r);
    blk_c.row  = epx_pkg::POS_W'(s_row_r);
    blk_c.q    = epx_pkg::epx_corners(s_px_r, c_up, c_left, s_px_r, s_px_r);
    blk_c.done = 1'b1;
  end

  // lowest pending slot goes first
  always_comb begin
    pick    = '0;
    blk_sel = blk_c;
    if (pend_r[epx_pkg::SLOT_ABOVE]) begin
      pick[epx_pkg::SLOT_ABOVE] = 1'b1;
      blk_sel = blk_a;
    end else if (pend_r[epx_pkg::SLOT_LEFT]) begin
      pick[epx_pkg::SLOT_LEFT] = 1'b1;
      blk_sel = blk_b;
    end else if (pend_r[epx_pkg::SLOT_FINAL]) begin
      pick[epx_pkg::SLOT_FINAL] = 1'b1;
    end
  end

  // ---------------- handshake and output register ----------------
  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = out_free && (pend_r != '0);
  assign pend_left = load_out ? (pend_r & ~pick) : pend_r;
  assign in_ready  = (pend_left == '0);
  assign in_acc    = in_valid && in_ready;
  assign pend_nxt  = in_acc ? new_mask : pend_left;

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blk_r <= blk_sel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_col    = out_blk_r.col;
  assign out_block_row    = out_blk_r.row;
  assign out_top_left     = out_blk_r.q.tl;
  assign out_top_right    = out_blk_r.q.tr;
  assign out_bottom_left  = out_blk_r.q.bl;
  assign out_bottom_right = out_blk_r.q.br;
  assign out_frame_done   = out_blk_r.done;

endmodule

// ----- rtl/epx_checker.sv -----
// port-level checker for the epx upscaler and its bind
`timescale 1ns / 1ps
`include "epx_pixel_upscale_2x_defines.svh"

module epx_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [epx_pkg::POS_W-1:0] out_block_col,
  input logic [epx_pkg::POS_W-1:0] out_block_row,
  input logic [epx_pkg::PIX_W-1:0] out_top_left,
  input logic [epx_pkg::PIX_W-1:0] out_top_right,
  input logic [epx_pkg::PIX_W-1:0] out_bottom_left,
  input logic [epx_pkg::PIX_W-1:0] out_bottom_right,
  input logic                      out_frame_done
);

  // a stalled result keeps its col, row, top_left, bottom_right and done
  `EPX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_block_col) && $stable(out_block_row) && $stable(out_top_left) && $stable(out_bottom_right) && $stable(out_frame_done), "stalled output block changed")

  // the final block sits in the corner: right and down repeat the centre
  `EPX_ASSERT(a_final_corners, out_valid && out_frame_done |-> out_top_right == out_bottom_left && out_bottom_left == out_bottom_right, "final block corners disagree")

  // reset empties the output register
  `EPX_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind epx_pixel_upscale_2x epx_checker u_epx_checker (.*);

// ----- sim/tb_epx_pixel_upscale_2x.sv -----
// self-checking testbench for the epx 2x pixel-art upscaler
`timescale 1ns / 1ps

module tb_epx_pixel_upscale_2x;

  localparam int          MAX_W         = 1024;
  localparam int          MAX_H         = 1024;
  localparam int unsigned LIMIT         = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RANDOM_PIXELS = 50;
  localparam int unsigned EXTREME_RUN   = 8;
  localparam int unsigned MAX_PRINTS    = 40;
  // index with no register behind it, writes to it change nothing
  localparam logic [epx_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  epx_pkg::px_t                  in_pixel_in;
  logic                          out_valid;
  logic                          out_ready;
  logic [epx_pkg::POS_W-1:0]     out_block_col;
  logic [epx_pkg::POS_W-1:0]     out_block_row;
  epx_pkg::px_t                  out_top_left;
  epx_pkg::px_t                  out_top_right;
  epx_pkg::px_t                  out_bottom_left;
  epx_pkg::px_t                  out_bottom_right;
  logic                          out_frame_done;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [epx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [epx_pkg::DIM_W-1:0]     cfg_data;

  // predictor state
  logic [epx_pkg::DIM_W-1:0] width_reg;
  logic [epx_pkg::DIM_W-1:0] height_reg;
  epx_pkg::px_t              line_mem [0:2*MAX_W-1];
  epx_pkg::px_t              last_px;
  epx_pkg::px_t              prev_px;
  int unsigned               col_cnt;
  int unsigned               row_cnt;
  epx_pkg::blk_t             pending_blocks [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle;

  epx_pixel_upscale_2x #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned eff_size(logic [epx_pkg::DIM_W-1:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return 32'(v);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_block(int unsigned col, int unsigned row, epx_pkg::px_t p,
                                      epx_pkg::px_t up, epx_pkg::px_t left,
                                      epx_pkg::px_t right, epx_pkg::px_t down, logic done);
    epx_pkg::blk_t b;
    b.col  = col[epx_pkg::POS_W-1:0];
    b.row  = row[epx_pkg::POS_W-1:0];
    b.q.tl = (left == up && left != down && up != right) ? up : p;
    b.q.tr = (up == right && up != left && right != down) ? right : p;
    b.q.bl = (down == left && down != right && left != up) ? left : p;
    b.q.br = (right == down && right != up && down != left) ? down : p;
    b.done = done;
    pending_blocks.push_back(b);
  endfunction

  // blocks released by one accepted pixel, in output order
  function automatic void upscale_pixel(epx_pkg::px_t px);
    int unsigned w, h, c, r, cur, prv;
    epx_pkg::px_t p, up, left, right;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    cur = (r % 2) * MAX_W;
    prv = ((r + 1) % 2) * MAX_W;
    if (r >= 1) begin
      p     = line_mem[prv + c];
      up    = (r >= 2) ? line_mem[cur + c] : p;
      left  = (c > 0) ? line_mem[prv + c - 1] : p;
      right = (c + 1 < w) ? line_mem[prv + c + 1] : p;
      queue_block(c, r - 1, p, up, left, right, px, 1'b0);
    end
    if (r == h - 1) begin
      // last row: the block left of this pixel is now complete
      if (c >= 1) begin
        p    = last_px;
        left = (c >= 2) ? prev_px : p;
        up   = (r >= 1) ? line_mem[prv + c - 1] : p;
        queue_block(c - 1, r, p, up, left, px, p, 1'b0);
      end
      if (c == w - 1) begin
        left = (c >= 1) ? last_px : px;
        up   = (r >= 1) ? line_mem[prv + c] : px;
        queue_block(c, r, px, up, left, px, px, 1'b1);
      end
    end
    line_mem[cur + c] = px;
    prev_px = last_px;
    last_px = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want, input epx_pkg::blk_t blk);
    if (got != want)
      report_mismatch($sformatf("block (%0d,%0d) %s got %0h want %0h",
                                blk.col, blk.row, name, got, want));
  endtask

  always @(posedge clk) begin : check_output
    epx_pkg::blk_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected block at col %0d row %0d",
                                  out_block_col, out_block_row));
      end else begin
        want = pending_blocks.pop_front();
        compare_field("block_col", 32'(out_block_col), 32'(want.col), want);
        compare_field("block_row", 32'(out_block_row), 32'(want.row), want);
        compare_field("top_left", 32'(out_top_left), 32'(want.q.tl), want);
        compare_field("top_right", 32'(out_top_right), 32'(want.q.tr), want);
        compare_field("bottom_left", 32'(out_bottom_left), 32'(want.q.bl), want);
        compare_field("bottom_right", 32'(out_bottom_right), 32'(want.q.br), want);
        compare_field("frame_done", 32'(out_frame_done), 32'(want.done), want);
      end
    end
  end

  initial begin : ready_driver
    int unsigned n;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_pixel(input epx_pkg::px_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    upscale_pixel(px);
  endtask

  // few colors so that neighbors match often, with some arbitrary bytes mixed in
  task automatic send_run(input int unsigned count);
    epx_pkg::px_t pal [3];
    int unsigned k;
    for (k = 0; k < 3; k++) pal[k] = $urandom_range(0, 255);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) send_pixel(epx_pkg::px_t'($urandom_range(0, 255)));
      else send_pixel(pal[$urandom_range(0, 2)]);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [epx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [epx_pkg::DIM_W-1:0] data);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == epx_pkg::REG_SOURCE_WIDTH || idx == epx_pkg::REG_SOURCE_HEIGHT) begin
      if (idx == epx_pkg::REG_SOURCE_WIDTH) width_reg = data;
      else height_reg = data;
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  // no config write: the first row after reset is 320 wide, so nothing comes out yet
  task automatic test_reset_size();
    no_idle = 1'b1;
    send_run(6);
    no_idle = 1'b0;
  endtask

  task automatic test_corner_rules();
    epx_pkg::px_t frame_a [9];
    epx_pkg::px_t frame_b [9];
    int unsigned k;
    // centre sees up = left and right = down
    frame_a = '{8'h01, 8'h01, 8'h03,
                8'h01, 8'h05, 8'h02,
                8'h04, 8'h02, 8'h02};
    // centre sees up = right and left = down, at the byte extremes
    frame_b = '{8'h00, 8'hFF, 8'hFF,
                8'h00, 8'h80, 8'hFF,
                8'h00, 8'h00, 8'h7F};
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd3);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd3);
    for (k = 0; k < 9; k++) send_pixel(frame_a[k]);
    for (k = 0; k < 9; k++) send_pixel(frame_b[k]);
    // a zero width counts as one: every pixel is a whole frame
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd0);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd1);
    send_pixel(8'hA5);
    send_pixel(8'h5A);
  endtask

  task automatic test_frame_boundaries();
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd3);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd3);
    send_run(4);
    // unmapped index must not restart the frame
    write_reg(REG_UNMAPPED, 11'd5);
    send_run(5);
    send_run(2);
    // restart in the middle of a frame
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd2);
    send_run(12);
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd1);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd3);
    send_run(3);
  endtask

  task automatic test_size_extremes();
    no_idle = 1'b1;
    // oversize width on one row: every pixel but the first closes the block to its left
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd2047);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd0);
    send_run(EXTREME_RUN);
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd1);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd1024);
    send_run(EXTREME_RUN);
    // oversize height on a narrow frame
    write_reg(epx_pkg::REG_SOURCE_WIDTH, 11'd2);
    write_reg(epx_pkg::REG_SOURCE_HEIGHT, 11'd2047);
    send_run(EXTREME_RUN);
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned sent, total, count, which;
    logic [epx_pkg::DIM_W-1:0] w, h;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      no_idle = (sent < RANDOM_PIXELS / 4);
      w = epx_pkg::DIM_W'($urandom_range(0, 6));
      h = epx_pkg::DIM_W'($urandom_range(0, 5));
      which = (sent == 0) ? 2 : $urandom_range(0, 2);
      if (which != 1) write_reg(epx_pkg::REG_SOURCE_WIDTH, w);
      if (which != 0) write_reg(epx_pkg::REG_SOURCE_HEIGHT, h);
      total = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
      case ($urandom_range(0, 4))
        0: begin
          count = $urandom_range(1, total);
        end
        1: begin
          count = 2 * total;
        end
        default: begin
          count = total;
        end
      endcase
      if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
      send_run(count);
      sent += count;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = epx_pkg::REG_SOURCE_WIDTH;
    cfg_data    = '0;
    no_idle     = 1'b0;
    width_reg   = 11'd320;
    height_reg  = 11'd200;
    last_px     = '0;
    prev_px     = '0;
    col_cnt     = 0;
    row_cnt     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_corner_rules();
    test_frame_boundaries();
    test_size_extremes();
    test_random_frames();
    settle_idle();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/epx_pkg.sv
rtl/epx_line_store.sv
rtl/epx_pixel_upscale_2x.sv
rtl/epx_checker.sv
sim/tb_epx_pixel_upscale_2x.sv
